[rtl/mjv_pkg.sv]
// Shared types, constants and helper functions for the joint velocity solver.
// Used by mjv_ctrl, mjv_dp and mover_joint_velocity_solver; no dependencies.
package mjv_pkg;

    // Fixed point format
    localparam int FRAC_BITS = 16;
    localparam int SAT_W     = 66;

    // Effective mass divider: numerator 2^(2*FRAC_BITS)
    localparam int DIV_BITS  = 2 * FRAC_BITS + 1;
    localparam int DIV_CNT_W = $clog2(DIV_BITS);
    localparam int QUO_W     = (DIV_BITS > 32) ? DIV_BITS : 32;

    // Micro-op program length (longest sequence, solve)
    localparam int SEQ_LEN = 12;
    localparam int STEP_W  = $clog2(SEQ_LEN);

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = -32'sh7FFF_FFFF - 32'sh1;
    localparam logic [30:0]        U31_MAX = 31'h7FFF_FFFF;

    // Register reset values
    localparam logic [30:0] STEP_TIME_RST     = 31'd1092;
    localparam logic [30:0] INV_STEP_TIME_RST = 31'd3932160;

    typedef enum logic [2:0] {
        CFG_TARGET_VEL_X  = 3'd0,
        CFG_TARGET_VEL_Y  = 3'd1,
        CFG_MAX_FORCE_X   = 3'd2,
        CFG_MAX_FORCE_Y   = 3'd3,
        CFG_STEP_TIME     = 3'd4,
        CFG_INV_STEP_TIME = 3'd5,
        CFG_WARM_START    = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_PREPARE = 2'd0,
        MODE_WARM    = 2'd1,
        MODE_SOLVE   = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_RUN,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        SEQ_FORCE,
        SEQ_WARM,
        SEQ_SOLVE
    } seq_t;

    // One op per cycle on the shared multiplier; each op is retired in the next cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_MX,      // step_time * max_force_x, also relative velocity x
        OP_MY,
        OP_IX,      // effective_mass * cx, accumulate and clamp
        OP_IY,
        OP_DIFF,    // impulse deltas, no multiply
        OP_WAX,     // inv_mass_a * acc_impulse_x
        OP_WAY,
        OP_WBX,
        OP_WBY,
        OP_SAX,     // inv_mass_a * delta_x
        OP_SAY,
        OP_SBX,
        OP_SBY,
        OP_FX,      // inv_step_time * acc_impulse_x
        OP_FY
    } op_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic div_last;
        op_t  op;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic limits_zero;
    } status_t;

    // Saturate a wide signed value to 32-bit signed
    function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
        if (v > SAT_W'(S32_MAX)) begin
            return S32_MAX;
        end
        if (v < SAT_W'(S32_MIN)) begin
            return S32_MIN;
        end
        return 32'(v);
    endfunction

    // Micro-op program for each sequence kind
    function automatic op_t seq_op(input seq_t seq, input logic [STEP_W-1:0] step);
        op_t op;
        op = OP_NONE;
        case (seq)
            SEQ_WARM: begin
                case (step)
                    4'd0:    op = OP_WAX;
                    4'd1:    op = OP_WAY;
                    4'd2:    op = OP_WBX;
                    4'd3:    op = OP_WBY;
                    4'd4:    op = OP_FX;
                    4'd5:    op = OP_FY;
                    default: op = OP_NONE;
                endcase
            end
            SEQ_SOLVE: begin
                case (step)
                    4'd0:    op = OP_MX;
                    4'd1:    op = OP_MY;
                    4'd2:    op = OP_IX;
                    4'd3:    op = OP_IY;
                    4'd4:    op = OP_DIFF;
                    4'd5:    op = OP_FX;
                    4'd6:    op = OP_SAX;
                    4'd7:    op = OP_FY;
                    4'd8:    op = OP_SAY;
                    4'd9:    op = OP_SBX;
                    4'd10:   op = OP_SBY;
                    default: op = OP_NONE;
                endcase
            end
            default: begin
                case (step)
                    4'd0:    op = OP_FX;
                    4'd1:    op = OP_FY;
                    default: op = OP_NONE;
                endcase
            end
        endcase
        return op;
    endfunction

endpackage

[rtl/mjv_ctrl.sv]
// Sequencer for the joint velocity solver: handshakes, divider count, op program.
// Depends on mjv_pkg; drives mjv_dp through cmd_t and reads status_t.
module mjv_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_mode,
    output logic             m_valid,
    input  logic             m_ready,
    input  mjv_pkg::status_t status,
    output mjv_pkg::cmd_t    cmd
);
    import mjv_pkg::*;

    state_t                 state_reg, state_next;
    seq_t                   seq_reg, seq_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic                   m_valid_reg, m_valid_next;
    op_t                    cur_op;

    // State and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            seq_reg     <= SEQ_FORCE;
            step_reg    <= '0;
            div_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            seq_reg     <= seq_next;
            step_reg    <= step_next;
            div_cnt_reg <= div_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign cur_op = seq_op(seq_reg, step_reg);

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        seq_next     = seq_reg;
        step_next    = step_reg;
        div_cnt_next = div_cnt_reg;
        m_valid_next = m_valid_reg;
        s_ready      = 1'b0;
        cmd          = '{load: 1'b0, div_step: 1'b0, div_last: 1'b0,
                         op: OP_NONE, out_load: 1'b0};

        // result beat leaves the output register
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load     = 1'b1;
                    step_next    = '0;
                    div_cnt_next = '0;
                    if (s_mode == MODE_WARM) begin
                        seq_next = SEQ_WARM;
                    end else if (s_mode == MODE_SOLVE && !status.limits_zero) begin
                        seq_next = SEQ_SOLVE;
                    end else begin
                        seq_next = SEQ_FORCE;
                    end
                    if (s_mode == MODE_PREPARE) begin
                        state_next = ST_DIV;
                    end else begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(DIV_BITS - 1)) begin
                    cmd.div_last = 1'b1;
                    state_next   = ST_RUN;
                end else begin
                    div_cnt_next = div_cnt_reg + 1'b1;
                end
            end
            ST_RUN: begin
                cmd.op = cur_op;
                // the closing OP_NONE retires the last multiply
                if (cur_op == OP_NONE) begin
                    state_next = ST_DONE;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("output register overwritten while a beat is pending");

    a_prep_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_mode == MODE_PREPARE) |=> (state_reg == ST_DIV))
        else $error("prepare beat did not start the divider");

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (step_reg < STEP_W'(SEQ_LEN)))
        else $error("op program ran past its end");

    a_div_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (div_cnt_reg <= DIV_CNT_W'(DIV_BITS - 1)))
        else $error("divider count out of range");

    a_done_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && m_valid_reg && !m_ready) |=> (state_reg == ST_DONE))
        else $error("result left DONE while the receiver stalled");

endmodule

[rtl/mjv_dp.sv]
// Datapath of the joint velocity solver: config registers, solver state, shared
// multiplier, restoring divider and output register. Depends on mjv_pkg.
module mjv_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  mjv_pkg::cmd_t       cmd,
    output mjv_pkg::status_t    status,
    // configuration
    input  logic                cfg_valid,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    // input beat
    input  logic [1:0]          s_mode,
    input  logic signed [31:0]  s_vel_a_x,
    input  logic signed [31:0]  s_vel_a_y,
    input  logic signed [31:0]  s_vel_b_x,
    input  logic signed [31:0]  s_vel_b_y,
    input  logic [30:0]         s_inv_mass_a,
    input  logic [30:0]         s_inv_mass_b,
    input  logic                s_awake_a,
    input  logic                s_awake_b,
    input  logic                s_dynamic_a,
    input  logic                s_dynamic_b,
    // result beat
    output logic signed [31:0]  m_new_vel_a_x,
    output logic signed [31:0]  m_new_vel_a_y,
    output logic signed [31:0]  m_new_vel_b_x,
    output logic signed [31:0]  m_new_vel_b_y,
    output logic                m_write_a,
    output logic                m_write_b,
    output logic signed [31:0]  m_impulse_x,
    output logic signed [31:0]  m_impulse_y,
    output logic signed [31:0]  m_force_x,
    output logic signed [31:0]  m_force_y
);
    import mjv_pkg::*;

    // Configuration
    logic signed [31:0] tvx_reg, tvx_next, tvy_reg, tvy_next;
    logic [30:0]        mfx_reg, mfx_next, mfy_reg, mfy_next;
    logic [30:0]        step_t_reg, step_t_next, inv_step_reg, inv_step_next;
    logic               warm_en_reg, warm_en_next;

    // Solver state
    logic signed [31:0] acc_x_reg, acc_x_next, acc_y_reg, acc_y_next;
    logic [30:0]        em_reg, em_next;
    logic [30:0]        sima_reg, sima_next, simb_reg, simb_next;
    logic               saw_a_reg, saw_a_next, saw_b_reg, saw_b_next;
    op_t                ret_op_reg;

    // Working registers
    logic signed [31:0] va_x_reg, va_x_next, va_y_reg, va_y_next;
    logic signed [31:0] vb_x_reg, vb_x_next, vb_y_reg, vb_y_next;
    logic               wr_a_reg, wr_a_next, wr_b_reg, wr_b_next;
    logic signed [31:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [31:0] mx_reg, mx_next, my_reg, my_next;
    logic signed [31:0] ox_reg, ox_next, oy_reg, oy_next;
    logic signed [31:0] dx_reg, dx_next, dy_reg, dy_next;
    logic signed [31:0] fx_reg, fx_next, fy_reg, fy_next;
    logic signed [63:0] prod_reg, prod_next;

    // Divider
    logic [31:0]         k_reg, k_next;
    logic [31:0]         rem_reg, rem_next;
    logic [DIV_BITS-1:0] num_reg, num_next, quo_reg, quo_next;

    // Output register
    logic signed [31:0] o_va_x_reg, o_va_y_reg, o_vb_x_reg, o_vb_y_reg;
    logic signed [31:0] o_imp_x_reg, o_imp_y_reg, o_fx_reg, o_fy_reg;
    logic               o_wr_a_reg, o_wr_b_reg;

    logic signed [32:0] mul_a, mul_b;
    logic signed [31:0] q;
    logic signed [31:0] neg_q;
    logic [32:0]        rem_sh;
    logic               div_ge;
    logic               use_awake;
    logic               clear_acc;

    function automatic logic signed [31:0] clamp_lim(input logic signed [31:0] v,
                                                     input logic signed [31:0] lim);
        logic signed [31:0] nlim;
        nlim = -lim;
        if (v > lim) begin
            return lim;
        end
        if (v < nlim) begin
            return nlim;
        end
        return v;
    endfunction

    assign status.limits_zero = (mfx_reg == '0) && (mfy_reg == '0);

    // Multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_MX:  begin mul_a = $signed({2'b00, step_t_reg}); mul_b = $signed({2'b00, mfx_reg}); end
            OP_MY:  begin mul_a = $signed({2'b00, step_t_reg}); mul_b = $signed({2'b00, mfy_reg}); end
            OP_IX:  begin mul_a = $signed({2'b00, em_reg}); mul_b = 33'(cx_reg); end
            OP_IY:  begin mul_a = $signed({2'b00, em_reg}); mul_b = 33'(cy_reg); end
            OP_WAX: begin mul_a = $signed({2'b00, sima_reg}); mul_b = 33'(acc_x_reg); end
            OP_WAY: begin mul_a = $signed({2'b00, sima_reg}); mul_b = 33'(acc_y_reg); end
            OP_WBX: begin mul_a = $signed({2'b00, simb_reg}); mul_b = 33'(acc_x_reg); end
            OP_WBY: begin mul_a = $signed({2'b00, simb_reg}); mul_b = 33'(acc_y_reg); end
            OP_SAX: begin mul_a = $signed({2'b00, sima_reg}); mul_b = 33'(dx_reg); end
            OP_SAY: begin mul_a = $signed({2'b00, sima_reg}); mul_b = 33'(dy_reg); end
            OP_SBX: begin mul_a = $signed({2'b00, simb_reg}); mul_b = 33'(dx_reg); end
            OP_SBY: begin mul_a = $signed({2'b00, simb_reg}); mul_b = 33'(dy_reg); end
            OP_FX:  begin mul_a = $signed({2'b00, inv_step_reg}); mul_b = 33'(acc_x_reg); end
            OP_FY:  begin mul_a = $signed({2'b00, inv_step_reg}); mul_b = 33'(acc_y_reg); end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Product fits 63 bits; floor shift and saturate on retire
    assign prod_next = 64'(mul_a * mul_b);
    assign q         = sat32(SAT_W'(prod_reg >>> FRAC_BITS));
    assign neg_q     = sat32(-SAT_W'(q));

    // Divider step
    assign rem_sh = {rem_reg, num_reg[DIV_BITS-1]};
    assign div_ge = rem_sh >= {1'b0, k_reg};

    assign use_awake = (s_mode == MODE_WARM) || (s_mode == MODE_SOLVE);
    assign clear_acc = ((s_mode == MODE_PREPARE) && !warm_en_reg) ||
                       ((s_mode == MODE_SOLVE) && status.limits_zero);

    always_comb begin
        tvx_next      = tvx_reg;
        tvy_next      = tvy_reg;
        mfx_next      = mfx_reg;
        mfy_next      = mfy_reg;
        step_t_next   = step_t_reg;
        inv_step_next = inv_step_reg;
        warm_en_next  = warm_en_reg;
        acc_x_next    = acc_x_reg;
        acc_y_next    = acc_y_reg;
        em_next       = em_reg;
        sima_next     = sima_reg;
        simb_next     = simb_reg;
        saw_a_next    = saw_a_reg;
        saw_b_next    = saw_b_reg;
        va_x_next     = va_x_reg;
        va_y_next     = va_y_reg;
        vb_x_next     = vb_x_reg;
        vb_y_next     = vb_y_reg;
        wr_a_next     = wr_a_reg;
        wr_b_next     = wr_b_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        mx_next       = mx_reg;
        my_next       = my_reg;
        ox_next       = ox_reg;
        oy_next       = oy_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        fx_next       = fx_reg;
        fy_next       = fy_reg;
        k_next        = k_reg;
        rem_next      = rem_reg;
        num_next      = num_reg;
        quo_next      = quo_reg;

        // Register writes
        if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_TARGET_VEL_X:  tvx_next      = cfg_data;
                CFG_TARGET_VEL_Y:  tvy_next      = cfg_data;
                CFG_MAX_FORCE_X:   mfx_next      = cfg_data[30:0];
                CFG_MAX_FORCE_Y:   mfy_next      = cfg_data[30:0];
                CFG_STEP_TIME:     step_t_next   = cfg_data[30:0];
                CFG_INV_STEP_TIME: inv_step_next = cfg_data[30:0];
                CFG_WARM_START:    warm_en_next  = cfg_data[0];
                default: ;
            endcase
        end

        // Input beat: sleeping bodies read as zero in warm start and solve
        if (cmd.load) begin
            va_x_next = (use_awake && !saw_a_reg) ? '0 : s_vel_a_x;
            va_y_next = (use_awake && !saw_a_reg) ? '0 : s_vel_a_y;
            vb_x_next = (use_awake && !saw_b_reg) ? '0 : s_vel_b_x;
            vb_y_next = (use_awake && !saw_b_reg) ? '0 : s_vel_b_y;
            wr_a_next = use_awake && saw_a_reg && s_dynamic_a;
            wr_b_next = use_awake && saw_b_reg && s_dynamic_b;
            if (s_mode == MODE_PREPARE) begin
                sima_next  = s_inv_mass_a;
                simb_next  = s_inv_mass_b;
                saw_a_next = s_awake_a;
                saw_b_next = s_awake_b;
                k_next     = {1'b0, s_inv_mass_a} + {1'b0, s_inv_mass_b};
                rem_next   = '0;
                num_next   = {1'b1, {(DIV_BITS-1){1'b0}}};
                quo_next   = '0;
            end
            if (clear_acc) begin
                acc_x_next = '0;
                acc_y_next = '0;
            end
        end

        // Restoring division, one quotient bit a cycle
        if (cmd.div_step) begin
            rem_next = div_ge ? 32'(rem_sh - {1'b0, k_reg}) : 32'(rem_sh);
            num_next = {num_reg[DIV_BITS-2:0], 1'b0};
            quo_next = {quo_reg[DIV_BITS-2:0], div_ge};
            if (cmd.div_last) begin
                if (k_reg == '0) begin
                    em_next = '0;
                end else if (QUO_W'(quo_next) > QUO_W'(U31_MAX)) begin
                    em_next = U31_MAX;
                end else begin
                    em_next = 31'(quo_next);
                end
            end
        end

        // Retire the multiply issued last cycle
        case (ret_op_reg)
            OP_MX: begin
                mx_next = q;
                cx_next = sat32(SAT_W'(vb_x_reg) - SAT_W'(va_x_reg) - SAT_W'(tvx_reg));
            end
            OP_MY: begin
                my_next = q;
                cy_next = sat32(SAT_W'(vb_y_reg) - SAT_W'(va_y_reg) - SAT_W'(tvy_reg));
            end
            OP_IX: begin
                ox_next    = acc_x_reg;
                acc_x_next = clamp_lim(sat32(SAT_W'(acc_x_reg) + SAT_W'(neg_q)), mx_reg);
            end
            OP_IY: begin
                oy_next    = acc_y_reg;
                acc_y_next = clamp_lim(sat32(SAT_W'(acc_y_reg) + SAT_W'(neg_q)), my_reg);
            end
            OP_DIFF: begin
                dx_next = sat32(SAT_W'(acc_x_reg) - SAT_W'(ox_reg));
                dy_next = sat32(SAT_W'(acc_y_reg) - SAT_W'(oy_reg));
            end
            OP_WAX, OP_SAX: va_x_next = sat32(SAT_W'(va_x_reg) - SAT_W'(q));
            OP_WAY, OP_SAY: va_y_next = sat32(SAT_W'(va_y_reg) - SAT_W'(q));
            OP_WBX, OP_SBX: vb_x_next = sat32(SAT_W'(vb_x_reg) + SAT_W'(q));
            OP_WBY, OP_SBY: vb_y_next = sat32(SAT_W'(vb_y_reg) + SAT_W'(q));
            OP_FX: fx_next = q;
            OP_FY: fy_next = q;
            default: ;
        endcase
    end

    // Control and architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tvx_reg      <= '0;
            tvy_reg      <= '0;
            mfx_reg      <= '0;
            mfy_reg      <= '0;
            step_t_reg   <= STEP_TIME_RST;
            inv_step_reg <= INV_STEP_TIME_RST;
            warm_en_reg  <= 1'b1;
            acc_x_reg    <= '0;
            acc_y_reg    <= '0;
            em_reg       <= '0;
            sima_reg     <= '0;
            simb_reg     <= '0;
            saw_a_reg    <= 1'b0;
            saw_b_reg    <= 1'b0;
            ret_op_reg   <= OP_NONE;
        end else begin
            tvx_reg      <= tvx_next;
            tvy_reg      <= tvy_next;
            mfx_reg      <= mfx_next;
            mfy_reg      <= mfy_next;
            step_t_reg   <= step_t_next;
            inv_step_reg <= inv_step_next;
            warm_en_reg  <= warm_en_next;
            acc_x_reg    <= acc_x_next;
            acc_y_reg    <= acc_y_next;
            em_reg       <= em_next;
            sima_reg     <= sima_next;
            simb_reg     <= simb_next;
            saw_a_reg    <= saw_a_next;
            saw_b_reg    <= saw_b_next;
            ret_op_reg   <= cmd.op;
        end
    end

    // Working payload
    always_ff @(posedge aclk) begin
        va_x_reg <= va_x_next;
        va_y_reg <= va_y_next;
        vb_x_reg <= vb_x_next;
        vb_y_reg <= vb_y_next;
        wr_a_reg <= wr_a_next;
        wr_b_reg <= wr_b_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        ox_reg   <= ox_next;
        oy_reg   <= oy_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        fx_reg   <= fx_next;
        fy_reg   <= fy_next;
        prod_reg <= prod_next;
        k_reg    <= k_next;
        rem_reg  <= rem_next;
        num_reg  <= num_next;
        quo_reg  <= quo_next;
    end

    // Output register, loaded once the result is complete
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            o_va_x_reg  <= va_x_reg;
            o_va_y_reg  <= va_y_reg;
            o_vb_x_reg  <= vb_x_reg;
            o_vb_y_reg  <= vb_y_reg;
            o_wr_a_reg  <= wr_a_reg;
            o_wr_b_reg  <= wr_b_reg;
            o_imp_x_reg <= acc_x_reg;
            o_imp_y_reg <= acc_y_reg;
            o_fx_reg    <= fx_reg;
            o_fy_reg    <= fy_reg;
        end
    end

    assign m_new_vel_a_x = o_va_x_reg;
    assign m_new_vel_a_y = o_va_y_reg;
    assign m_new_vel_b_x = o_vb_x_reg;
    assign m_new_vel_b_y = o_vb_y_reg;
    assign m_write_a     = o_wr_a_reg;
    assign m_write_b     = o_wr_b_reg;
    assign m_impulse_x   = o_imp_x_reg;
    assign m_impulse_y   = o_imp_y_reg;
    assign m_force_x     = o_fx_reg;
    assign m_force_y     = o_fy_reg;

    a_clamp_x: assert property (@(posedge aclk) disable iff (!aresetn)
        (ret_op_reg == OP_IX) |=> (acc_x_reg <= mx_reg && acc_x_reg >= -mx_reg))
        else $error("accumulated impulse x escaped its clamp");

    a_clamp_y: assert property (@(posedge aclk) disable iff (!aresetn)
        (ret_op_reg == OP_IY) |=> (acc_y_reg <= my_reg && acc_y_reg >= -my_reg))
        else $error("accumulated impulse y escaped its clamp");

    a_em_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.div_last && k_reg == '0) |=> (em_reg == '0))
        else $error("zero mass sum gave nonzero effective mass");

endmodule

[rtl/mover_joint_velocity_solver.sv]
// Top level of the two-body joint velocity solver (sequential impulses, Q16.16).
// Depends on mjv_pkg, mjv_ctrl and mjv_dp.
//
// Usage:
//   Input beats (s_*) carry a mode and two bodies; one result beat (m_*) comes
//   back per input beat. Mode 0 prepares (latches masses and awake marks,
//   divides for the effective mass), mode 1 warm starts, mode 2 runs one solve
//   iteration. Registers are written on the cfg_* port, index 0..6, and the
//   user must write them only while idle; the block does not enforce this.
//   cfg_ready is always high. Prepare runs the restoring divider at one
//   quotient bit per cycle, then the force ops; warm start and solve run
//   their op programs, and solve with both force limits zero, like mode 3,
//   runs only the force ops. All multiplies go through one 33x33
//   multiplier, one op per cycle. One beat at a time: s_ready rises
//   together with m_valid once the result is loaded, so no input beat is
//   taken while another is in progress.
//   Reset (synchronous, aresetn low) clears the solver state and sets registers
//   to their defaults; no result is pending afterwards.
//   A stalled receiver holds the result in the output register; the next input
//   beat is still taken and processed, and its result waits for the register.
module mover_joint_velocity_solver (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    // input channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_mode,
    input  logic signed [31:0]  s_vel_a_x,
    input  logic signed [31:0]  s_vel_a_y,
    input  logic signed [31:0]  s_vel_b_x,
    input  logic signed [31:0]  s_vel_b_y,
    input  logic [30:0]         s_inv_mass_a,
    input  logic [30:0]         s_inv_mass_b,
    input  logic                s_awake_a,
    input  logic                s_awake_b,
    input  logic                s_dynamic_a,
    input  logic                s_dynamic_b,
    // result channel
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_new_vel_a_x,
    output logic signed [31:0]  m_new_vel_a_y,
    output logic signed [31:0]  m_new_vel_b_x,
    output logic signed [31:0]  m_new_vel_b_y,
    output logic                m_write_a,
    output logic                m_write_b,
    output logic signed [31:0]  m_impulse_x,
    output logic signed [31:0]  m_impulse_y,
    output logic signed [31:0]  m_force_x,
    output logic signed [31:0]  m_force_y
);
    import mjv_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    mjv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_mode),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mjv_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_mode        (s_mode),
        .s_vel_a_x     (s_vel_a_x),
        .s_vel_a_y     (s_vel_a_y),
        .s_vel_b_x     (s_vel_b_x),
        .s_vel_b_y     (s_vel_b_y),
        .s_inv_mass_a  (s_inv_mass_a),
        .s_inv_mass_b  (s_inv_mass_b),
        .s_awake_a     (s_awake_a),
        .s_awake_b     (s_awake_b),
        .s_dynamic_a   (s_dynamic_a),
        .s_dynamic_b   (s_dynamic_b),
        .m_new_vel_a_x (m_new_vel_a_x),
        .m_new_vel_a_y (m_new_vel_a_y),
        .m_new_vel_b_x (m_new_vel_b_x),
        .m_new_vel_b_y (m_new_vel_b_y),
        .m_write_a     (m_write_a),
        .m_write_b     (m_write_b),
        .m_impulse_x   (m_impulse_x),
        .m_impulse_y   (m_impulse_y),
        .m_force_x     (m_force_x),
        .m_force_y     (m_force_y)
    );

endmodule

[test/mover_joint_velocity_solver_tb.sv]
// Self-checking testbench for mover_joint_velocity_solver: a scoreboard class
// predicts each result beat; tasks drive config and input, an initial block m_ready.
// Depends on mjv_pkg and the solver RTL only.
module mover_joint_velocity_solver_tb;
    import mjv_pkg::*;

    localparam longint LIM_HI       = 64'sd2147483647;
    localparam longint LIM_LO       = -64'sd2147483648;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES    = 48;
    localparam int CYCLE_LIMIT      = 800000;
    localparam int MAX_REPORTS      = 100;
    localparam int RANDOM_PHASES    = 8;
    localparam int PHASE_ITEMS      = 245;

    // One input beat
    typedef struct {
        logic [1:0]         mode;
        logic signed [31:0] va_x, va_y, vb_x, vb_y;
        logic [30:0]        im_a, im_b;
        logic               aw_a, aw_b, dyn_a, dyn_b;
    } body_pair_t;

    // One result beat
    typedef struct {
        logic signed [31:0] va_x, va_y, vb_x, vb_y;
        logic               wr_a, wr_b;
        logic signed [31:0] imp_x, imp_y, f_x, f_y;
    } motion_t;

    // Velocity solver predictor plus queue of expected velocity updates
    class joint_scoreboard;
        longint tgt_x, tgt_y, fmax_x, fmax_y, h_step, inv_h;
        bit     warm_keep;
        longint imp_x, imp_y, m_eff, st_ima, st_imb;
        bit     st_awa, st_awb;
        motion_t expected_updates[$];
        int errors, n_inputs, n_results, n_reported;

        function new();
            tgt_x = 0; tgt_y = 0; fmax_x = 0; fmax_y = 0;
            h_step = longint'(STEP_TIME_RST);
            inv_h = longint'(INV_STEP_TIME_RST);
            warm_keep = 1'b1;
            imp_x = 0; imp_y = 0; m_eff = 0; st_ima = 0; st_imb = 0;
            st_awa = 1'b0; st_awb = 1'b0;
            errors = 0; n_inputs = 0; n_results = 0; n_reported = 0;
        endfunction

        function longint clip32(longint v);
            if (v > LIM_HI) return LIM_HI;
            if (v < LIM_LO) return LIM_LO;
            return v;
        endfunction

        // Q16.16 product, floor, saturated
        function longint fmul(longint a, longint b);
            longint p;
            p = a * b;
            return clip32(p >>> FRAC_BITS);
        endfunction

        function longint clamp_abs(longint v, longint lim);
            if (v > lim) return lim;
            if (v < -lim) return -lim;
            return v;
        endfunction

        function int pending();
            return expected_updates.size();
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] d);
            case (cfg_idx_t'(idx))
                CFG_TARGET_VEL_X:  tgt_x = longint'($signed(d));
                CFG_TARGET_VEL_Y:  tgt_y = longint'($signed(d));
                CFG_MAX_FORCE_X:   fmax_x = longint'(d[30:0]);
                CFG_MAX_FORCE_Y:   fmax_y = longint'(d[30:0]);
                CFG_STEP_TIME:     h_step = longint'(d[30:0]);
                CFG_INV_STEP_TIME: inv_h = longint'(d[30:0]);
                CFG_WARM_START:    warm_keep = d[0];
                default: ;
            endcase
        endfunction

        // Predict the velocity update caused by one accepted input beat
        function void note_input(body_pair_t p);
            motion_t e;
            longint ax, ay, bx, by, k, r, cx, cy, ix, iy, ox, oy, mx, my, dx, dy;
            bit wa, wb;
            ax = p.va_x; ay = p.va_y; bx = p.vb_x; by = p.vb_y;
            wa = 1'b0; wb = 1'b0;
            n_inputs++;
            case (p.mode)
                MODE_PREPARE: begin
                    st_ima = longint'(p.im_a);
                    st_imb = longint'(p.im_b);
                    st_awa = p.aw_a;
                    st_awb = p.aw_b;
                    k = st_ima + st_imb;
                    if (k == 0) begin
                        m_eff = 0;
                    end else begin
                        r = (longint'(1) << (2 * FRAC_BITS)) / k;
                        m_eff = (r > LIM_HI) ? LIM_HI : r;
                    end
                    if (!warm_keep) begin
                        imp_x = 0;
                        imp_y = 0;
                    end
                end
                MODE_WARM, MODE_SOLVE: begin
                    // sleeping bodies read as zero
                    if (!st_awa) begin
                        ax = 0; ay = 0;
                    end
                    if (!st_awb) begin
                        bx = 0; by = 0;
                    end
                    wa = st_awa && p.dyn_a;
                    wb = st_awb && p.dyn_b;
                    if (p.mode == MODE_WARM) begin
                        ax = clip32(ax - fmul(st_ima, imp_x));
                        ay = clip32(ay - fmul(st_ima, imp_y));
                        bx = clip32(bx + fmul(st_imb, imp_x));
                        by = clip32(by + fmul(st_imb, imp_y));
                    end else if (fmax_x > 0 || fmax_y > 0) begin
                        cx = clip32(bx - ax - tgt_x);
                        cy = clip32(by - ay - tgt_y);
                        ix = clip32(-fmul(m_eff, cx));
                        iy = clip32(-fmul(m_eff, cy));
                        ox = imp_x;
                        oy = imp_y;
                        mx = fmul(h_step, fmax_x);
                        my = fmul(h_step, fmax_y);
                        imp_x = clamp_abs(clip32(ox + ix), mx);
                        imp_y = clamp_abs(clip32(oy + iy), my);
                        dx = clip32(imp_x - ox);
                        dy = clip32(imp_y - oy);
                        ax = clip32(ax - fmul(st_ima, dx));
                        ay = clip32(ay - fmul(st_ima, dy));
                        bx = clip32(bx + fmul(st_imb, dx));
                        by = clip32(by + fmul(st_imb, dy));
                    end else begin
                        // both force limits zero
                        imp_x = 0;
                        imp_y = 0;
                    end
                end
                default: ;
            endcase
            e.va_x = 32'(ax); e.va_y = 32'(ay);
            e.vb_x = 32'(bx); e.vb_y = 32'(by);
            e.wr_a = wa; e.wr_b = wb;
            e.imp_x = 32'(imp_x); e.imp_y = 32'(imp_y);
            e.f_x = 32'(fmul(inv_h, imp_x));
            e.f_y = 32'(fmul(inv_h, imp_y));
            expected_updates.push_back(e);
        endfunction

        function void cmp(string name, logic [31:0] e, logic [31:0] g);
            if (e !== g) begin
                errors++;
                if (n_reported < MAX_REPORTS) begin
                    n_reported++;
                    $display("%0t: %s mismatch, expected %0d, actual %0d",
                             $time, name, $signed(e), $signed(g));
                end
            end
        endfunction

        function void check_result(motion_t got);
            motion_t e;
            n_results++;
            if (expected_updates.size() == 0) begin
                errors++;
                if (n_reported < MAX_REPORTS) begin
                    n_reported++;
                    $display("%0t: result beat with no input beat pending", $time);
                end
                return;
            end
            e = expected_updates.pop_front();
            cmp("new_vel_a_x", e.va_x, got.va_x);
            cmp("new_vel_a_y", e.va_y, got.va_y);
            cmp("new_vel_b_x", e.vb_x, got.vb_x);
            cmp("new_vel_b_y", e.vb_y, got.vb_y);
            cmp("write_a", {31'd0, e.wr_a}, {31'd0, got.wr_a});
            cmp("write_b", {31'd0, e.wr_b}, {31'd0, got.wr_b});
            cmp("impulse_x", e.imp_x, got.imp_x);
            cmp("impulse_y", e.imp_y, got.imp_y);
            cmp("force_x", e.f_x, got.f_x);
            cmp("force_y", e.f_y, got.f_y);
        endfunction
    endclass

    logic               aclk;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_mode = '0;
    logic signed [31:0] s_vel_a_x = '0, s_vel_a_y = '0, s_vel_b_x = '0, s_vel_b_y = '0;
    logic [30:0]        s_inv_mass_a = '0, s_inv_mass_b = '0;
    logic               s_awake_a = 1'b0, s_awake_b = 1'b0;
    logic               s_dynamic_a = 1'b0, s_dynamic_b = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_new_vel_a_x, m_new_vel_a_y, m_new_vel_b_x, m_new_vel_b_y;
    logic               m_write_a, m_write_b;
    logic signed [31:0] m_impulse_x, m_impulse_y, m_force_x, m_force_y;

    joint_scoreboard sb = new();
    bit no_idle = 1'b0;
    int n_settings = 0;

    mover_joint_velocity_solver dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_vel_a_x     (s_vel_a_x),
        .s_vel_a_y     (s_vel_a_y),
        .s_vel_b_x     (s_vel_b_x),
        .s_vel_b_y     (s_vel_b_y),
        .s_inv_mass_a  (s_inv_mass_a),
        .s_inv_mass_b  (s_inv_mass_b),
        .s_awake_a     (s_awake_a),
        .s_awake_b     (s_awake_b),
        .s_dynamic_a   (s_dynamic_a),
        .s_dynamic_b   (s_dynamic_b),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_new_vel_a_x (m_new_vel_a_x),
        .m_new_vel_a_y (m_new_vel_a_y),
        .m_new_vel_b_x (m_new_vel_b_x),
        .m_new_vel_b_y (m_new_vel_b_y),
        .m_write_a     (m_write_a),
        .m_write_b     (m_write_b),
        .m_impulse_x   (m_impulse_x),
        .m_impulse_y   (m_impulse_y),
        .m_force_x     (m_force_x),
        .m_force_y     (m_force_y)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("simulation failed");
        $finish;
    end

    // Register writes go to the predictor as they are accepted
    always @(posedge aclk) begin
        if (aresetn && cfg_valid && cfg_ready) begin
            sb.set_reg(cfg_index, cfg_data);
        end
    end

    // Input beats
    always @(posedge aclk) begin : input_mon
        body_pair_t p;
        if (aresetn && s_valid && s_ready) begin
            p.mode = s_mode;
            p.va_x = s_vel_a_x; p.va_y = s_vel_a_y;
            p.vb_x = s_vel_b_x; p.vb_y = s_vel_b_y;
            p.im_a = s_inv_mass_a; p.im_b = s_inv_mass_b;
            p.aw_a = s_awake_a; p.aw_b = s_awake_b;
            p.dyn_a = s_dynamic_a; p.dyn_b = s_dynamic_b;
            sb.note_input(p);
        end
    end

    // Result beats
    always @(posedge aclk) begin : result_mon
        motion_t got;
        if (aresetn && m_valid && m_ready) begin
            got.va_x = m_new_vel_a_x; got.va_y = m_new_vel_a_y;
            got.vb_x = m_new_vel_b_x; got.vb_y = m_new_vel_b_y;
            got.wr_a = m_write_a; got.wr_b = m_write_b;
            got.imp_x = m_impulse_x; got.imp_y = m_impulse_y;
            got.f_x = m_force_x; got.f_y = m_force_y;
            sb.check_result(got);
        end
    end

    // Receiver back-pressure in bursts
    initial begin
        forever begin
            m_ready <= 1'b1;
            if (no_idle) begin
                @(posedge aclk);
            end else begin
                repeat ($urandom_range(1, 40)) @(posedge aclk);
                if ($urandom_range(0, 1) == 1 && !no_idle) begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(1, 16)) @(posedge aclk);
                end
            end
        end
    end

    function automatic int idle_gap();
        if (no_idle) return 0;
        if ($urandom_range(0, 3) == 0) return $urandom_range(1, 16);
        return 0;
    endfunction

    function automatic logic signed [31:0] rand_vel();
        case ($urandom_range(0, 9))
            0:       return S32_MIN;
            1:       return S32_MAX;
            2, 3, 4, 5: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
            default: return $signed($urandom);
        endcase
    endfunction

    // Mostly values in 1..span, sometimes usual, the extremes or full range
    function automatic logic [30:0] pick_u31(logic [30:0] usual, int unsigned span);
        case ($urandom_range(0, 9))
            0:       return 31'd0;
            1:       return U31_MAX;
            2:       return 31'd1;
            3:       return usual;
            4:       return 31'($urandom) & U31_MAX;
            default: return 31'($urandom_range(1, span));
        endcase
    endfunction

    function automatic body_pair_t mk_pair(logic [1:0] m, logic signed [31:0] ax, ay, bx, by,
                                           logic [30:0] ma, mb, logic wa, wb, da, db);
        body_pair_t p;
        p.mode = m;
        p.va_x = ax; p.va_y = ay; p.vb_x = bx; p.vb_y = by;
        p.im_a = ma; p.im_b = mb;
        p.aw_a = wa; p.aw_b = wb; p.dyn_a = da; p.dyn_b = db;
        return p;
    endfunction

    function automatic body_pair_t rand_pair(logic [1:0] m);
        return mk_pair(m, rand_vel(), rand_vel(), rand_vel(), rand_vel(),
                       pick_u31(31'd65536, 1 << 18), pick_u31(31'd65536, 1 << 18),
                       $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0,
                       $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
    endfunction

    // Present one input beat and hold it until accepted
    task automatic send_pair(body_pair_t p, int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_mode       <= p.mode;
        s_vel_a_x    <= p.va_x;
        s_vel_a_y    <= p.va_y;
        s_vel_b_x    <= p.vb_x;
        s_vel_b_y    <= p.vb_y;
        s_inv_mass_a <= p.im_a;
        s_inv_mass_b <= p.im_b;
        s_awake_a    <= p.aw_a;
        s_awake_b    <= p.aw_b;
        s_dynamic_a  <= p.dyn_a;
        s_dynamic_b  <= p.dyn_b;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid, wait for every expected result, then let the block go quiet
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(cfg_idx_t idx, logic [31:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic apply_settings(logic signed [31:0] tx, ty, logic [30:0] fx, fy, st, ist,
                                  logic ws);
        cfg_write(CFG_TARGET_VEL_X, tx);
        cfg_write(CFG_TARGET_VEL_Y, ty);
        cfg_write(CFG_MAX_FORCE_X, {1'b0, fx});
        cfg_write(CFG_MAX_FORCE_Y, {1'b0, fy});
        cfg_write(CFG_STEP_TIME, {1'b0, st});
        cfg_write(CFG_INV_STEP_TIME, {1'b0, ist});
        cfg_write(CFG_WARM_START, {31'd0, ws});
        cfg_valid <= 1'b0;
        @(posedge aclk);
        n_settings++;
    endtask

    task automatic directed_items();
        // reset settings: zero force limits, mode 3 and empty masses
        send_pair(mk_pair(MODE_UNUSED, S32_MAX, S32_MIN, S32_MAX, S32_MIN,
                          U31_MAX, U31_MAX, 1, 1, 1, 1), 0);
        send_pair(mk_pair(MODE_PREPARE, 1000, 2000, -3000, 4000, 0, 0, 1, 1, 1, 1), 0);
        send_pair(mk_pair(MODE_WARM, S32_MIN, S32_MAX, S32_MAX, S32_MIN, 0, 0, 0, 0, 1, 1), 0);
        send_pair(mk_pair(MODE_SOLVE, 65536, -65536, 131072, 0, 0, 0, 0, 0, 1, 1), 0);
        settle();

        // widest limits, saturating effective mass and products
        apply_settings(32'sh0001_2345, -32'sh0002_0000, U31_MAX, U31_MAX, U31_MAX, U31_MAX, 1);
        send_pair(mk_pair(MODE_PREPARE, S32_MIN, S32_MAX, S32_MAX, S32_MIN, 1, 0, 1, 1, 1, 1), 0);
        send_pair(mk_pair(MODE_SOLVE, S32_MIN, S32_MAX, S32_MAX, S32_MIN, 0, 0, 0, 0, 1, 1), 0);
        send_pair(mk_pair(MODE_WARM, S32_MAX, S32_MIN, S32_MIN, S32_MAX, 0, 0, 0, 0, 1, 1), 0);
        send_pair(mk_pair(MODE_SOLVE, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0), 0);
        // body A asleep, largest masses
        send_pair(mk_pair(MODE_PREPARE, 0, 0, 0, 0, U31_MAX, U31_MAX, 0, 1, 0, 0), 0);
        send_pair(mk_pair(MODE_WARM, S32_MAX, S32_MAX, S32_MAX, S32_MAX, 0, 0, 1, 1, 1, 1), 0);
        send_pair(mk_pair(MODE_SOLVE, S32_MIN, S32_MIN, S32_MAX, S32_MAX, 0, 0, 1, 1, 1, 1), 0);
        // unit masses, body B asleep
        send_pair(mk_pair(MODE_PREPARE, 0, 0, 0, 0, 65536, 65536, 1, 0, 1, 1), 0);
        send_pair(mk_pair(MODE_SOLVE, 300000, -70000, -5000, 9000, 0, 0, 1, 1, 1, 1), 0);
        send_pair(mk_pair(MODE_SOLVE, 0, 0, 0, 0, 0, 0, 1, 1, 1, 1), 0);
        settle();

        // warm start off clears the impulse on prepare; zero clamp on x
        apply_settings(S32_MIN, S32_MAX, 31'd1, 31'd0, 31'd0, 31'd0, 0);
        send_pair(mk_pair(MODE_PREPARE, 0, 0, 0, 0, 65536, 32768, 1, 1, 1, 1), 0);
        send_pair(mk_pair(MODE_SOLVE, 100, 200, -300, 400, 0, 0, 1, 1, 1, 1), 0);
        send_pair(mk_pair(MODE_WARM, 100, 200, -300, 400, 0, 0, 1, 1, 0, 1), 0);
        send_pair(mk_pair(MODE_UNUSED, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
        settle();

        // typical motor settings
        apply_settings(32'sh0007_0000, -32'sh0003_0000, 31'd0, 31'h0005_0000,
                       STEP_TIME_RST, INV_STEP_TIME_RST, 1);
        send_pair(mk_pair(MODE_PREPARE, 0, 0, 0, 0, 65536, 131072, 1, 1, 1, 1), 0);
        send_pair(mk_pair(MODE_SOLVE, 65536, 0, -65536, 32768, 0, 0, 1, 1, 1, 1), 0);
        send_pair(mk_pair(MODE_SOLVE, 65536, 0, -65536, 32768, 0, 0, 1, 1, 1, 1), 0);
        send_pair(mk_pair(MODE_WARM, 0, 0, 0, 0, 0, 0, 1, 1, 1, 1), 0);
        settle();
    endtask

    // Mostly prepare / warm start / solve runs, with some stray and unused modes
    task automatic random_phase(int count);
        int sent;
        int n;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 7) == 0) begin
                send_pair(rand_pair(2'($urandom_range(0, 3))), idle_gap());
                sent++;
            end else begin
                send_pair(rand_pair(MODE_PREPARE), idle_gap());
                sent++;
                if ($urandom_range(0, 2) != 0) begin
                    send_pair(rand_pair(MODE_WARM), idle_gap());
                    sent++;
                end
                n = $urandom_range(1, 6);
                repeat (n) begin
                    send_pair(rand_pair(MODE_SOLVE), idle_gap());
                    sent++;
                end
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        directed_items();
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph == RANDOM_PHASES - 1) begin
                no_idle = 1'b1;
            end
            apply_settings(rand_vel(), rand_vel(),
                           pick_u31(31'h0004_0000, 1 << 22), pick_u31(31'h0004_0000, 1 << 22),
                           pick_u31(STEP_TIME_RST, 1 << 17),
                           pick_u31(INV_STEP_TIME_RST, 1 << 24),
                           $urandom_range(0, 1));
            random_phase(PHASE_ITEMS);
            settle();
        end
        $display("covered %0d input beats and %0d result beats over %0d register settings",
                 sb.n_inputs, sb.n_results, n_settings);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
